/* design/ddfc_pkg.sv */
// Shared types, codes and helpers of the display data fetcher cartridge.
`default_nettype none
package ddfc_pkg;

  localparam int unsigned ProgAw  = 13;
  localparam int unsigned DispAw  = 11;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CountW  = 11;
  localparam int unsigned Fetchers = 8;

  localparam logic [15:0] XnorTable = 16'h9669;

  localparam logic [11:0] Bank0Addr = 12'hFF8;
  localparam logic [11:0] Bank1Addr = 12'hFF9;

  localparam logic [2:0] RdRandom  = 3'd0;
  localparam logic [2:0] RdDisplay = 3'd1;
  localparam logic [2:0] RdMasked  = 3'd2;
  localparam logic [2:0] RdFlag    = 3'd7;

  localparam logic [2:0] WrTop     = 3'd0;
  localparam logic [2:0] WrBottom  = 3'd1;
  localparam logic [2:0] WrCountLo = 3'd2;
  localparam logic [2:0] WrCountHi = 3'd3;
  localparam logic [2:0] WrRandRst = 3'd6;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_PROG  = 2'd1,
    SRC_DISP  = 2'd2
  } src_e;

  typedef struct packed {
    logic            clk_rand;
    logic            fread;
    logic            fwrite;
    logic [IdxW-1:0] idx;
    logic [2:0]      fn;
    logic [7:0]      wdata;
  } fetch_req_t;

  typedef struct packed {
    logic [7:0]        rand_next;
    logic              flag_next;
    logic [CountW-1:0] count;
  } fetch_rsp_t;

  function automatic logic [7:0] lfsr_next(input logic [7:0] r);
    return {r[6:0], XnorTable[{r[7], r[5:3]}]};
  endfunction

endpackage
`default_nettype wire

/* design/ddfc_item_if.sv */
// Input item channel of the cartridge.
`default_nettype none
interface ddfc_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] address;
  logic [7:0]  write_data;
  logic [13:0] image_address;
  logic [7:0]  image_byte;

  modport source (
    output valid, operation, address, write_data, image_address, image_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, address, write_data, image_address, image_byte,
    output ready
  );
endinterface
`default_nettype wire

/* design/ddfc_result_if.sv */
// Result item channel of the cartridge.
`default_nettype none
interface ddfc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (
    output valid, read_data,
    input  ready
  );
  modport sink (
    input  valid, read_data,
    output ready
  );
endinterface
`default_nettype wire

/* design/ddfc_fetchers.sv */
// Eight fetcher register sets and the random shift register.
`default_nettype none
module ddfc_fetchers (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       fire_i,
  input  wire ddfc_pkg::fetch_req_t req_i,
  output ddfc_pkg::fetch_rsp_t      rsp_o
);

  logic [ddfc_pkg::CountW-1:0] count_q [ddfc_pkg::Fetchers];
  logic [7:0]                  top_q   [ddfc_pkg::Fetchers];
  logic [7:0]                  bot_q   [ddfc_pkg::Fetchers];
  logic [ddfc_pkg::Fetchers-1:0] flag_q;
  logic [7:0]                  rand_q;

  logic [ddfc_pkg::CountW-1:0] cnt_cur;
  logic                        flag_upd;
  logic [7:0]                  rand_clk;

  always_comb begin
    cnt_cur = count_q[req_i.idx];
    if (cnt_cur[7:0] == top_q[req_i.idx]) begin
      flag_upd = 1'b1;
    end else if (cnt_cur[7:0] == bot_q[req_i.idx]) begin
      flag_upd = 1'b0;
    end else begin
      flag_upd = flag_q[req_i.idx];
    end
    rand_clk = req_i.clk_rand ? ddfc_pkg::lfsr_next(rand_q) : rand_q;
  end

  assign rsp_o.rand_next = rand_clk;
  assign rsp_o.flag_next = flag_upd;
  assign rsp_o.count     = cnt_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ddfc_pkg::Fetchers; i++) begin
        count_q[i] <= '0;
        top_q[i]   <= '0;
        bot_q[i]   <= '0;
      end
      flag_q <= '0;
      rand_q <= 8'd1;
    end else if (fire_i) begin
      if (req_i.fwrite && (req_i.fn == ddfc_pkg::WrRandRst)) begin
        rand_q <= 8'd1;
      end else begin
        rand_q <= rand_clk;
      end
      if (req_i.fread) begin
        flag_q[req_i.idx] <= flag_upd;
        if (req_i.fn inside {ddfc_pkg::RdDisplay, ddfc_pkg::RdMasked, ddfc_pkg::RdFlag}) begin
          count_q[req_i.idx] <= cnt_cur - 11'd1;
        end
      end
      if (req_i.fwrite) begin
        case (req_i.fn)
          ddfc_pkg::WrTop:     top_q[req_i.idx] <= req_i.wdata;
          ddfc_pkg::WrBottom:  bot_q[req_i.idx] <= req_i.wdata;
          ddfc_pkg::WrCountLo: count_q[req_i.idx] <= {cnt_cur[10:8], req_i.wdata};
          ddfc_pkg::WrCountHi: begin
            count_q[req_i.idx] <= {req_i.wdata[2:0], cnt_cur[7:0]};
            flag_q[req_i.idx]  <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* design/display_data_fetcher_cartridge.sv */
// Top level of the display data fetcher cartridge.
// Result path: an accepted item goes through the input register, then the registered image read
// and result select of the result stage.
// Throughput: one item per cycle; input ready drops only while both stages hold an item
// and the result is not taken.
// Reset: fetcher registers cleared, random register one, bank one; images undefined.
`default_nettype none
module display_data_fetcher_cartridge (
  input  wire            clk_i,
  input  wire            rst_ni,
  ddfc_item_if.sink      item_i,
  ddfc_result_if.source  result_o
);

  logic                   v1_q, v2_q;
  ddfc_pkg::op_e          op1_q;
  logic [11:0]            addr1_q;
  logic [7:0]             wdata1_q;
  logic [13:0]            iaddr1_q;
  logic [7:0]             ibyte1_q;

  logic                   bank_q, bank_d;
  ddfc_pkg::src_e         src2_q, src2_d;
  logic [7:0]             const2_q, const2_d;
  logic [7:0]             mask2_q, mask2_d;

  logic [7:0] prog_mem [2**ddfc_pkg::ProgAw];
  logic [7:0] disp_mem [2**ddfc_pkg::DispAw];
  logic [7:0] prog_rdata_q, disp_rdata_q;

  logic adv, fire2, accept;
  logic is_read, is_write, is_load, fetch_rd, fetch_wr;
  logic prog_re, prog_we, disp_re, disp_we;
  logic [ddfc_pkg::ProgAw-1:0] prog_raddr;
  logic [ddfc_pkg::DispAw-1:0] disp_raddr;

  ddfc_pkg::fetch_req_t req;
  ddfc_pkg::fetch_rsp_t rsp;

  assign adv          = !v2_q || result_o.ready;
  assign fire2        = v1_q && adv;
  assign item_i.ready = !v1_q || adv;
  assign accept       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (fire2) begin
        v1_q <= 1'b0;
      end
      if (adv) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op1_q    <= ddfc_pkg::op_e'(item_i.operation);
      addr1_q  <= item_i.address;
      wdata1_q <= item_i.write_data;
      iaddr1_q <= item_i.image_address;
      ibyte1_q <= item_i.image_byte;
    end
  end

  assign is_read  = (op1_q == ddfc_pkg::OP_READ);
  assign is_write = (op1_q == ddfc_pkg::OP_WRITE);
  assign is_load  = (op1_q == ddfc_pkg::OP_LOAD);
  assign fetch_rd = is_read && (addr1_q[11:6] == 6'd0);
  assign fetch_wr = is_write && (addr1_q[11:6] == 6'd1);

  always_comb begin
    req.clk_rand = is_read || is_write;
    req.fread    = fetch_rd;
    req.fwrite   = fetch_wr;
    req.idx      = addr1_q[2:0];
    req.fn       = addr1_q[5:3];
    req.wdata    = wdata1_q;
  end

  ddfc_fetchers u_fetchers (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire2),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_comb begin
    bank_d = bank_q;
    if (is_read || is_write) begin
      if (addr1_q == ddfc_pkg::Bank0Addr) begin
        bank_d = 1'b0;
      end else if (addr1_q == ddfc_pkg::Bank1Addr) begin
        bank_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b1;
    end else if (fire2) begin
      bank_q <= bank_d;
    end
  end

  always_comb begin
    src2_d   = ddfc_pkg::SRC_CONST;
    const2_d = 8'd0;
    mask2_d  = 8'd0;
    if (fetch_rd) begin
      case (req.fn)
        ddfc_pkg::RdRandom:  const2_d = addr1_q[2] ? 8'd0 : rsp.rand_next;
        ddfc_pkg::RdDisplay: begin
          src2_d  = ddfc_pkg::SRC_DISP;
          mask2_d = 8'hFF;
        end
        ddfc_pkg::RdMasked: begin
          src2_d  = ddfc_pkg::SRC_DISP;
          mask2_d = {8{rsp.flag_next}};
        end
        ddfc_pkg::RdFlag:    const2_d = {8{rsp.flag_next}};
        default: ;
      endcase
    end else if (is_read) begin
      src2_d = ddfc_pkg::SRC_PROG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src2_q <= ddfc_pkg::SRC_CONST;
    end else if (fire2) begin
      src2_q <= src2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire2) begin
      const2_q <= const2_d;
      mask2_q  <= mask2_d;
    end
  end

  assign prog_re    = fire2 && is_read && !fetch_rd;
  assign prog_we    = fire2 && is_load && !iaddr1_q[13];
  assign prog_raddr = {bank_d, addr1_q};
  assign disp_re    = fire2 && fetch_rd &&
                      (req.fn == ddfc_pkg::RdDisplay || req.fn == ddfc_pkg::RdMasked);
  assign disp_we    = fire2 && is_load && (iaddr1_q[13:11] == 3'b100);
  assign disp_raddr = ~rsp.count;

  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[iaddr1_q[ddfc_pkg::ProgAw-1:0]] <= ibyte1_q;
    end
    if (prog_re) begin
      prog_rdata_q <= prog_mem[prog_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (disp_we) begin
      disp_mem[iaddr1_q[ddfc_pkg::DispAw-1:0]] <= ibyte1_q;
    end
    if (disp_re) begin
      disp_rdata_q <= disp_mem[disp_raddr];
    end
  end

  assign result_o.valid = v2_q;

  always_comb begin
    case (src2_q)
      ddfc_pkg::SRC_PROG: result_o.read_data = prog_rdata_q;
      ddfc_pkg::SRC_DISP: result_o.read_data = disp_rdata_q & mask2_q;
      default:            result_o.read_data = const2_q;
    endcase
  end

  ap_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted item not held in input stage");

  ap_issue_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire2 |=> v2_q)
    else $error("issued item not held in result stage");

  ap_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !fire2) |=> v1_q)
    else $error("input stage item lost while stalled");

  ap_bank0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire2 && is_read && addr1_q == ddfc_pkg::Bank0Addr) |=> !bank_q)
    else $error("bank 0 hot spot did not select bank 0");

  ap_bank1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire2 && is_write && addr1_q == ddfc_pkg::Bank1Addr) |=> bank_q)
    else $error("bank 1 hot spot did not select bank 1");

endmodule
`default_nettype wire

/* sim/tb_display_data_fetcher_cartridge.sv */
// Self-checking testbench of the cartridge: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_display_data_fetcher_cartridge;

  localparam int ProgBytes   = 1 << ddfc_pkg::ProgAw;
  localparam int DispBytes   = 1 << ddfc_pkg::DispAw;
  localparam int ImageBytes  = ProgBytes + DispBytes;
  localparam int RandomItems = 1250;
  localparam int StallLimit  = 2000;
  localparam int IdlePct     = 28;
  localparam logic [11:0] FetchRdEnd = 12'h040;
  localparam logic [11:0] FetchWrEnd = 12'h080;

  typedef struct {
    ddfc_pkg::op_e op;
    logic [11:0]   addr;
    logic [7:0]    wdata;
    logic [13:0]   iaddr;
    logic [7:0]    ibyte;
  } bus_item_t;

  typedef struct {
    bus_item_t   acc;
    bit          typed;
    logic [7:0]  rd;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ddfc_item_if   item_if ();
  ddfc_result_if result_if ();

  display_data_fetcher_cartridge u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [ddfc_pkg::CountW-1:0] cnt_m [ddfc_pkg::Fetchers];
  logic [7:0]        top_m [ddfc_pkg::Fetchers];
  logic [7:0]        bot_m [ddfc_pkg::Fetchers];
  bit                flag_m [ddfc_pkg::Fetchers];
  logic [7:0]        lfsr_m;
  logic              bank_m;
  logic [7:0]        prog_img [ProgBytes];
  logic [7:0]        disp_img [DispBytes];
  bit                image_seen [ImageBytes];

  logic [7:0] expected_read_q [$];
  stim_row_t  directed_rows [$];
  logic [7:0] want_rd;
  int n_errors;
  int n_results;
  int n_items;
  int n_sweeps;
  int n_bursts;
  int stall_cycles;
  bit calm;

  function automatic logic [11:0] fetch_rd_addr(logic [2:0] fn, logic [2:0] idx);
    return {6'd0, fn, idx};
  endfunction

  function automatic logic [11:0] fetch_wr_addr(logic [2:0] fn, logic [2:0] idx);
    return FetchRdEnd | {6'd0, fn, idx};
  endfunction

  function automatic bus_item_t make_access(ddfc_pkg::op_e op, logic [11:0] addr,
                                            logic [7:0] wdata);
    bus_item_t a;
    a.op    = op;
    a.addr  = addr;
    a.wdata = wdata;
    a.iaddr = 14'($urandom_range(16383));
    a.ibyte = 8'($urandom_range(255));
    return a;
  endfunction

  function automatic void clock_lfsr();
    lfsr_m = {lfsr_m[6:0], ~(lfsr_m[7] ^ lfsr_m[5] ^ lfsr_m[4] ^ lfsr_m[3])};
  endfunction

  function automatic void pick_bank(logic [11:0] addr);
    if (addr == ddfc_pkg::Bank0Addr) bank_m = 1'b0;
    else if (addr == ddfc_pkg::Bank1Addr) bank_m = 1'b1;
  endfunction

  // image byte that the access will read, or -1
  function automatic int image_needed(bus_item_t a);
    logic [2:0] fn;
    logic       b;
    fn = a.addr[5:3];
    if (a.op != ddfc_pkg::OP_READ) return -1;
    if (a.addr < FetchRdEnd) begin
      if (fn == ddfc_pkg::RdDisplay || fn == ddfc_pkg::RdMasked)
        return ProgBytes + int'(~cnt_m[a.addr[2:0]]);
      return -1;
    end
    b = (a.addr == ddfc_pkg::Bank0Addr) ? 1'b0 :
        (a.addr == ddfc_pkg::Bank1Addr) ? 1'b1 : bank_m;
    return int'({b, a.addr});
  endfunction

  function automatic logic [7:0] predict_read_data(bus_item_t a);
    logic [2:0]                  idx;
    logic [2:0]                  fn;
    logic [ddfc_pkg::CountW-1:0] c;
    logic [7:0]                  rd;
    idx = a.addr[2:0];
    fn  = a.addr[5:3];
    rd  = 8'h00;
    case (a.op)
      ddfc_pkg::OP_READ: begin
        clock_lfsr();
        if (a.addr < FetchRdEnd) begin
          c = cnt_m[idx];
          if (c[7:0] == top_m[idx]) flag_m[idx] = 1'b1;
          else if (c[7:0] == bot_m[idx]) flag_m[idx] = 1'b0;
          case (fn)
            ddfc_pkg::RdRandom:  rd = idx[2] ? 8'h00 : lfsr_m;
            ddfc_pkg::RdDisplay: rd = disp_img[~c];
            ddfc_pkg::RdMasked:  rd = flag_m[idx] ? disp_img[~c] : 8'h00;
            ddfc_pkg::RdFlag:    rd = {8{flag_m[idx]}};
            default:             rd = 8'h00;
          endcase
          if (fn == ddfc_pkg::RdDisplay || fn == ddfc_pkg::RdMasked ||
              fn == ddfc_pkg::RdFlag) cnt_m[idx] = c - 1'b1;
        end else begin
          pick_bank(a.addr);
          rd = prog_img[{bank_m, a.addr}];
        end
      end
      ddfc_pkg::OP_WRITE: begin
        clock_lfsr();
        if (a.addr >= FetchRdEnd && a.addr < FetchWrEnd) begin
          case (fn)
            ddfc_pkg::WrTop:     top_m[idx] = a.wdata;
            ddfc_pkg::WrBottom:  bot_m[idx] = a.wdata;
            ddfc_pkg::WrCountLo: cnt_m[idx][7:0] = a.wdata;
            ddfc_pkg::WrCountHi: begin
              flag_m[idx] = 1'b0;
              cnt_m[idx][10:8] = a.wdata[2:0];
            end
            ddfc_pkg::WrRandRst: lfsr_m = 8'h01;
            default: ;
          endcase
        end else begin
          pick_bank(a.addr);
        end
      end
      ddfc_pkg::OP_LOAD: begin
        if (a.iaddr < ProgBytes) begin
          prog_img[a.iaddr[12:0]] = a.ibyte;
          image_seen[a.iaddr] = 1'b1;
        end else if (a.iaddr < ImageBytes) begin
          disp_img[a.iaddr[10:0]] = a.ibyte;
          image_seen[a.iaddr] = 1'b1;
        end
      end
      default: ;
    endcase
    return rd;
  endfunction

  task automatic deliver(bus_item_t a, bit typed, logic [7:0] typed_rd);
    logic [7:0] rd;
    while (!calm && $urandom_range(99) < IdlePct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.operation     <= a.op;
    item_if.address       <= a.addr;
    item_if.write_data    <= a.wdata;
    item_if.image_address <= a.iaddr;
    item_if.image_byte    <= a.ibyte;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    rd = predict_read_data(a);
    expected_read_q.push_back(typed ? typed_rd : rd);
    if (!(a.op == ddfc_pkg::OP_NONE || (a.op == ddfc_pkg::OP_LOAD && a.iaddr >= ImageBytes)))
      n_items++;
  endtask

  // load the image byte first if the access would read one never written
  task automatic send_access(bus_item_t a, bit typed, logic [7:0] typed_rd);
    int need;
    bus_item_t ld;
    need = image_needed(a);
    if (need >= 0 && !image_seen[need]) begin
      ld = make_access(ddfc_pkg::OP_LOAD, 12'($urandom_range(4095)), 8'($urandom_range(255)));
      ld.iaddr = 14'(need);
      deliver(ld, 1'b0, 8'h00);
    end
    deliver(a, typed, typed_rd);
  endtask

  task automatic add_row(ddfc_pkg::op_e op, logic [11:0] addr, logic [7:0] wdata,
                         logic [13:0] iaddr, logic [7:0] ibyte, bit typed, logic [7:0] rd);
    stim_row_t r;
    r.acc.op    = op;
    r.acc.addr  = addr;
    r.acc.wdata = wdata;
    r.acc.iaddr = iaddr;
    r.acc.ibyte = ibyte;
    r.typed     = typed;
    r.rd        = rd;
    directed_rows.push_back(r);
  endtask

  task automatic run_fetcher_sweep();
    logic [2:0]                  idx;
    logic [2:0]                  fn;
    logic [ddfc_pkg::CountW-1:0] c;
    logic [7:0]                  top;
    logic [7:0]                  bot;
    int lead;
    int span;
    int pick;
    idx  = 3'($urandom_range(7));
    c    = 11'($urandom_range(2047));
    lead = $urandom_range(0, 10);
    span = $urandom_range(0, 10);
    top  = c[7:0] - 8'(lead);
    bot  = top - 8'(span);
    send_access(make_access(ddfc_pkg::OP_WRITE, fetch_wr_addr(ddfc_pkg::WrTop, idx), top),
                1'b0, 8'h00);
    send_access(make_access(ddfc_pkg::OP_WRITE, fetch_wr_addr(ddfc_pkg::WrBottom, idx), bot),
                1'b0, 8'h00);
    send_access(make_access(ddfc_pkg::OP_WRITE, fetch_wr_addr(ddfc_pkg::WrCountLo, idx),
                            c[7:0]), 1'b0, 8'h00);
    send_access(make_access(ddfc_pkg::OP_WRITE, fetch_wr_addr(ddfc_pkg::WrCountHi, idx),
                            {5'($urandom_range(31)), c[10:8]}), 1'b0, 8'h00);
    repeat (lead + span + $urandom_range(1, 6)) begin
      pick = $urandom_range(99);
      fn = (pick < 30) ? ddfc_pkg::RdDisplay : (pick < 55) ? ddfc_pkg::RdMasked :
           (pick < 85) ? ddfc_pkg::RdFlag : (pick < 92) ? ddfc_pkg::RdRandom :
           3'($urandom_range(3, 6));
      send_access(make_access(ddfc_pkg::OP_READ, fetch_rd_addr(fn, idx),
                              8'($urandom_range(255))), 1'b0, 8'h00);
    end
    n_sweeps++;
  endtask

  task automatic run_program_burst();
    int pick;
    repeat ($urandom_range(4, 16)) begin
      pick = $urandom_range(99);
      if (pick < 12)
        send_access(make_access($urandom_range(1) ? ddfc_pkg::OP_WRITE : ddfc_pkg::OP_READ,
                                $urandom_range(1) ? ddfc_pkg::Bank1Addr : ddfc_pkg::Bank0Addr,
                                8'($urandom_range(255))), 1'b0, 8'h00);
      else
        send_access(make_access(ddfc_pkg::OP_READ, 12'($urandom_range(12'h040, 12'hFFF)),
                                8'($urandom_range(255))), 1'b0, 8'h00);
    end
    n_bursts++;
  endtask

  task automatic run_noise();
    bus_item_t a;
    repeat ($urandom_range(1, 8)) begin
      a = make_access(ddfc_pkg::op_e'($urandom_range(3)),
                      $urandom_range(1) ? 12'($urandom_range(127)) : 12'($urandom_range(4095)),
                      8'($urandom_range(255)));
      send_access(a, 1'b0, 8'h00);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      n_results++;
      if (expected_read_q.size() == 0) begin
        $error("read_data: no result expected, got %02h", result_if.read_data);
        n_errors++;
      end else begin
        want_rd = expected_read_q.pop_front();
        if (result_if.read_data !== want_rd) begin
          $error("read_data: expected %02h, got %02h", want_rd, result_if.read_data);
          n_errors++;
        end
      end
    end
    result_if.ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("tb_display_data_fetcher_cartridge: errors");
    $finish;
  end

  initial begin
    int base;
    int pick;
    rst_ni                = 1'b0;
    item_if.valid         = 1'b0;
    item_if.operation     = ddfc_pkg::OP_NONE;
    item_if.address       = '0;
    item_if.write_data    = '0;
    item_if.image_address = '0;
    item_if.image_byte    = '0;
    result_if.ready       = 1'b0;
    stall_cycles          = 0;
    n_errors              = 0;
    n_results             = 0;
    n_items               = 0;
    n_sweeps              = 0;
    n_bursts              = 0;
    calm                  = 1'b0;
    for (int i = 0; i < ddfc_pkg::Fetchers; i++) begin
      cnt_m[i]  = '0;
      top_m[i]  = '0;
      bot_m[i]  = '0;
      flag_m[i] = 1'b0;
    end
    lfsr_m = 8'h01;
    bank_m = 1'b1;

    add_row(ddfc_pkg::OP_READ, fetch_rd_addr(ddfc_pkg::RdRandom, 3'd0), 8'h00, 14'd0, 8'h00,
            1'b1, 8'h03);
    add_row(ddfc_pkg::OP_READ, fetch_rd_addr(ddfc_pkg::RdRandom, 3'd4), 8'hFF, 14'd0, 8'h00,
            1'b1, 8'h00);
    add_row(ddfc_pkg::OP_READ, fetch_rd_addr(ddfc_pkg::RdFlag, 3'd0), 8'h00, 14'd0, 8'h00,
            1'b1, 8'hFF);
    add_row(ddfc_pkg::OP_READ, fetch_rd_addr(ddfc_pkg::RdFlag, 3'd7), 8'h00, 14'd0, 8'h00,
            1'b1, 8'hFF);
    add_row(ddfc_pkg::OP_READ, fetch_rd_addr(3'd3, 3'd0), 8'h00, 14'd0, 8'h00, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_WRITE, fetch_wr_addr(ddfc_pkg::WrRandRst, 3'd0), 8'hFF, 14'd0, 8'h00,
            1'b1, 8'h00);
    add_row(ddfc_pkg::OP_READ, fetch_rd_addr(ddfc_pkg::RdRandom, 3'd3), 8'h00, 14'd0, 8'h00,
            1'b1, 8'h03);
    add_row(ddfc_pkg::OP_LOAD,  12'h000, 8'h00, 14'd0, 8'hA5, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_LOAD,  12'h000, 8'h00, 14'd10239, 8'h5A, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_LOAD,  12'hFFF, 8'hFF, 14'h3FFF, 8'hFF, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_NONE,  12'hFFF, 8'hFF, 14'h3FFF, 8'hFF, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_LOAD,  12'h000, 8'h00, 14'd8191, 8'hFF, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_READ,  12'hFFF, 8'h00, 14'd0, 8'h00, 1'b1, 8'hFF);
    add_row(ddfc_pkg::OP_LOAD,  12'h000, 8'h00, 14'h0FF8, 8'h11, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_READ,  ddfc_pkg::Bank0Addr, 8'h00, 14'd0, 8'h00, 1'b1, 8'h11);
    add_row(ddfc_pkg::OP_LOAD,  12'h000, 8'h00, 14'd4095, 8'h3C, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_READ,  12'hFFF, 8'h00, 14'd0, 8'h00, 1'b1, 8'h3C);
    add_row(ddfc_pkg::OP_WRITE, ddfc_pkg::Bank1Addr, 8'hFF, 14'd0, 8'h00, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_READ,  12'h040, 8'h00, 14'd0, 8'h00, 1'b0, 8'h00);
    add_row(ddfc_pkg::OP_WRITE, fetch_wr_addr(ddfc_pkg::WrTop, 3'd0), 8'hFF, 14'd0, 8'h00,
            1'b1, 8'h00);
    add_row(ddfc_pkg::OP_WRITE, fetch_wr_addr(ddfc_pkg::WrBottom, 3'd0), 8'h00, 14'd0, 8'h00,
            1'b1, 8'h00);
    add_row(ddfc_pkg::OP_WRITE, fetch_wr_addr(ddfc_pkg::WrCountLo, 3'd0), 8'hFF, 14'd0, 8'h00,
            1'b1, 8'h00);
    add_row(ddfc_pkg::OP_WRITE, fetch_wr_addr(ddfc_pkg::WrCountHi, 3'd0), 8'hFF, 14'd0, 8'h00,
            1'b1, 8'h00);
    add_row(ddfc_pkg::OP_WRITE, fetch_wr_addr(3'd4, 3'd0), 8'h00, 14'd0, 8'h00, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_WRITE, 12'h000, 8'h00, 14'd0, 8'h00, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_LOAD,  12'h000, 8'h00, 14'd8192, 8'h96, 1'b1, 8'h00);
    add_row(ddfc_pkg::OP_READ, fetch_rd_addr(ddfc_pkg::RdDisplay, 3'd0), 8'h00, 14'd0, 8'h00,
            1'b1, 8'h96);
    add_row(ddfc_pkg::OP_READ, fetch_rd_addr(ddfc_pkg::RdMasked, 3'd0), 8'h00, 14'd0, 8'h00,
            1'b0, 8'h00);
    add_row(ddfc_pkg::OP_READ, fetch_rd_addr(ddfc_pkg::RdFlag, 3'd0), 8'h00, 14'd0, 8'h00,
            1'b1, 8'hFF);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].rd);

    base = n_items;
    while (n_items - base < RandomItems) begin
      calm = (n_items - base >= 500) && (n_items - base < 700);
      pick = $urandom_range(99);
      if (pick < 45) run_fetcher_sweep();
      else if (pick < 75) run_program_burst();
      else run_noise();
    end
    calm = 1'b0;
    item_if.valid <= 1'b0;

    while (expected_read_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d items: %0d fetcher sweeps, %0d program bursts, rest noise.",
             n_items, n_sweeps, n_bursts);
    $display("Compared %0d results, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0)
      $display("tb_display_data_fetcher_cartridge: clean");
    else
      $display("tb_display_data_fetcher_cartridge: errors");
    $finish;
  end

endmodule

/* files.f */
design/ddfc_pkg.sv
design/ddfc_item_if.sv
design/ddfc_result_if.sv
design/ddfc_fetchers.sv
design/display_data_fetcher_cartridge.sv
sim/tb_display_data_fetcher_cartridge.sv
